FILE: rtl/two_level_pager_lfu_core_defines.svh
// Assertion macros used by the checker file of the pager core.
`ifndef TWO_LEVEL_PAGER_LFU_CORE_DEFINES_SVH
`define TWO_LEVEL_PAGER_LFU_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TLP_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pager check failed");
// Next-cycle implication checked outside reset.
`define TLP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pager check failed");
`endif

FILE: rtl/tlp_pkg.sv
// Package with the types and codes of the pager core.
package tlp_pkg;
  localparam int unsigned CountMax = 32'h0000FFFF;
  typedef enum logic [2:0] {
    OP_READ = 3'd0, OP_WRITE = 3'd1, OP_EXEC = 3'd2, OP_SETATTR = 3'd3,
    OP_LOADB = 3'd4, OP_INV5 = 3'd5, OP_INV6 = 3'd6, OP_INV7 = 3'd7
  } op_e;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BOUNDS = 3'd1, ST_PROC = 3'd2, ST_OWNER = 3'd3,
    ST_RDENY = 3'd4, ST_WRDENY = 3'd5, ST_EXDENY = 3'd6, ST_INVOP = 3'd7
  } status_e;
  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_LOOKUP, S_FREE, S_SCAN, S_SCANEND, S_OUTRD, S_OUTWR,
    S_INRD, S_INWR, S_FINISH, S_ACCESS, S_DONE
  } state_e;
  // Page table entry held in the page memory.
  typedef struct packed {
    logic [7:0]  owner;
    logic [2:0]  prot;
    logic        present;
    logic        dirty;
    logic [15:0] count;
    logic [7:0]  frame;
  } pte_t;
endpackage

FILE: rtl/tlp_page_mem.sv
// Page table memory: one write port, one registered read port.
module tlp_page_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = 6
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  tlp_pkg::pte_t  wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output tlp_pkg::pte_t  rdata_o
);
  import tlp_pkg::*;
  pte_t mem_q [DEPTH];
  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end
  // Registered read.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/tlp_byte_mem.sv
// Byte memory: one write port, one registered read port.
module tlp_byte_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem_q [DEPTH];
  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end
  // Registered read.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/two_level_pager_lfu_core.sv
// Top level of the two-level demand pager with LFU replacement.
// Usage: drive op_i, virt_addr_i, process_id_i, data_i and prot_i and raise
// start while busy is low; that edge is the transfer of one request.
// busy stays high until the result has been shown. Each result is on the
// result ports for exactly one cycle with done_o high; the receiver cannot
// stall, so it must take the transfer in that cycle.
// Request paths: an out-of-range address, a bad process number or op 4 go
// from the lookup straight to done; op 3 or an owner mismatch ends after the
// table read; a hit goes through the table read, access and done.
// A fault walks the free-frame bits one per cycle; with no free frame it
// scans the page table for the LFU victim. The page is then copied in byte
// by byte, a read state then a write state for each byte, and a dirty
// victim is first copied out in the same way. busy then goes low in the
// idle state, where the next request is taken.
// The page table and the byte memories each have one read and one write
// port, and those ports set the read and write steps above.
// After reset the block clears the page table, one entry per cycle, and
// holds busy high meanwhile. Frame usage is kept in flip-flops that reset
// clears. The byte memories are not cleared.
module two_level_pager_lfu_core #(
  parameter int unsigned PAGE_BYTES   = 16,
  parameter int unsigned SUB_ENTRIES  = 16,
  parameter int unsigned ROOT_ENTRIES = 4,
  parameter int unsigned FRAMES       = 8,
  parameter int unsigned PROCESSES    = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op_i,
  input  logic [10:0] virt_addr_i,
  input  logic [2:0] process_id_i,
  input  logic [7:0] data_i,
  input  logic [2:0] prot_i,
  output logic       done_o,
  output logic [2:0] status_o,
  output logic [6:0] phys_addr_o,
  output logic [7:0] read_data_o,
  output logic       page_fault_o,
  output logic       evicted_o,
  output logic       wrote_back_o
);
  import tlp_pkg::*;
  localparam int unsigned NPAGES = ROOT_ENTRIES * SUB_ENTRIES;
  localparam int unsigned VSIZE  = NPAGES * PAGE_BYTES;
  localparam int unsigned PSIZE  = FRAMES * PAGE_BYTES;
  localparam int unsigned PGW    = (NPAGES > 1) ? $clog2(NPAGES) : 1;
  localparam int unsigned OFW    = $clog2(PAGE_BYTES);
  localparam int unsigned FRW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned VAW    = $clog2(VSIZE);
  localparam int unsigned PAW    = $clog2(PSIZE);
  localparam int unsigned PGCW   = $clog2(NPAGES + 1);
  localparam int unsigned BCW    = $clog2(PAGE_BYTES + 1);

  state_e state_q, state_d;
  // Request registers.
  logic [2:0]  op_q;
  logic [10:0] va_q;
  logic [2:0]  pid_q;
  logic [7:0]  data_q;
  logic [2:0]  prot_q;
  // Working registers.
  pte_t            pte_q, pte_d;
  pte_t            vpte_q, vpte_d;
  logic [PGCW-1:0] idx_q, idx_d;
  logic [BCW-1:0]  bcnt_q, bcnt_d;
  logic [FRW-1:0]  frame_q, frame_d;
  logic [PGW-1:0]  victim_q, victim_d;
  logic [15:0]     best_q, best_d;
  logic            found_q, found_d, vdirty_q, vdirty_d;
  logic            pf_q, pf_d, ev_q, ev_d, wb_q, wb_d;
  logic [FRAMES-1:0] fused_q, fused_d;
  logic [2:0]  st_q, st_d;
  logic [6:0]  pa_q, pa_d;

  // Memory ports.
  logic           pt_we;
  logic [PGW-1:0] pt_waddr, pt_raddr;
  pte_t           pt_wdata, pt_rdata;
  logic           pm_we;
  logic [PAW-1:0] pm_waddr, pm_raddr;
  logic [7:0]     pm_wdata, pm_rdata;
  logic           bs_we;
  logic [VAW-1:0] bs_waddr, bs_raddr;
  logic [7:0]     bs_wdata, bs_rdata;

  tlp_page_mem #(.DEPTH(NPAGES), .AW(PGW)) u_pt (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .raddr_i(pt_raddr), .rdata_o(pt_rdata));
  tlp_byte_mem #(.DEPTH(PSIZE), .AW(PAW)) u_pm (
    .clk_i, .we_i(pm_we), .waddr_i(pm_waddr), .wdata_i(pm_wdata),
    .raddr_i(pm_raddr), .rdata_o(pm_rdata));
  tlp_byte_mem #(.DEPTH(VSIZE), .AW(VAW)) u_bs (
    .clk_i, .we_i(bs_we), .waddr_i(bs_waddr), .wdata_i(bs_wdata),
    .raddr_i(bs_raddr), .rdata_o(bs_rdata));

  // Address split: the page number is the address without its offset.
  logic [PGW-1:0] pg;
  logic [OFW-1:0] off;
  logic [PAW-1:0] pa_full;
  assign pg  = PGW'(va_q[VAW-1:OFW]);
  assign off = va_q[OFW-1:0];
  assign pa_full = {frame_q, off};

  // State register and request capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      fused_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fused_q <= fused_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q <= op_i;
      va_q <= virt_addr_i;
      pid_q <= process_id_i;
      data_q <= data_i;
      prot_q <= prot_i;
    end
    pte_q <= pte_d; vpte_q <= vpte_d; bcnt_q <= bcnt_d; frame_q <= frame_d;
    victim_q <= victim_d; best_q <= best_d; found_q <= found_d;
    vdirty_q <= vdirty_d; pf_q <= pf_d; ev_q <= ev_d; wb_q <= wb_d;
    st_q <= st_d; pa_q <= pa_d;
  end

  // Sequencer: next state, memory ports and result.
  always_comb begin
    state_d = state_q; idx_d = idx_q; fused_d = fused_q;
    pte_d = pte_q; vpte_d = vpte_q; bcnt_d = bcnt_q; frame_d = frame_q;
    victim_d = victim_q;
    best_d = best_q; found_d = found_q; vdirty_d = vdirty_q;
    pf_d = pf_q; ev_d = ev_q; wb_d = wb_q; st_d = st_q; pa_d = pa_q;
    pt_we = 1'b0; pt_waddr = pg; pt_wdata = pte_q; pt_raddr = pg;
    pm_we = 1'b0; pm_waddr = pa_full; pm_wdata = data_q; pm_raddr = pa_full;
    bs_we = 1'b0; bs_waddr = VAW'(va_q); bs_wdata = data_q; bs_raddr = VAW'(va_q);
    busy = 1'b1; done_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        pt_we = 1'b1; pt_waddr = idx_q[PGW-1:0]; pt_wdata = '0;
        if (idx_q == PGCW'(NPAGES - 1)) begin
          idx_d = '0; state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          st_d = ST_OK; pa_d = '0; pf_d = 1'b0; ev_d = 1'b0;
          wb_d = 1'b0; state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // Page table read issued in this cycle for pg.
        if (32'(va_q) >= VSIZE) begin
          st_d = ST_BOUNDS; state_d = S_DONE;
        end else if (op_q == OP_LOADB) begin
          bs_we = 1'b1; state_d = S_DONE;
        end else if (32'(pid_q) >= PROCESSES) begin
          st_d = ST_PROC; state_d = S_DONE;
        end else begin
          idx_d = '0; state_d = S_FREE;
        end
      end
      S_FREE: begin
        // First cycle here: the entry read arrives; keep it.
        if (idx_q == '0) begin
          pte_d = pt_rdata;
        end
        if (op_q == OP_SETATTR) begin
          pte_d = pt_rdata; pte_d.owner = 8'(pid_q); pte_d.prot = prot_q;
          pt_we = 1'b1; pt_wdata = pte_d; state_d = S_DONE;
        end else if (idx_q == '0 && pt_rdata.owner != 8'(pid_q)) begin
          st_d = ST_OWNER; state_d = S_DONE;
        end else if ((idx_q == '0 && pt_rdata.present) ||
                     (idx_q != '0 && pte_q.present)) begin
          frame_d = FRW'(((idx_q == '0) ? pt_rdata.frame : pte_q.frame) % FRAMES);
          state_d = S_ACCESS; bcnt_d = '0;
        end else if (32'(idx_q) >= FRAMES) begin
          // No free frame: scan the page table for the LFU victim.
          pf_d = 1'b1; idx_d = '0; found_d = 1'b0; state_d = S_SCAN;
        end else if (!fused_q[idx_q[FRW-1:0]]) begin
          pf_d = 1'b1; frame_d = idx_q[FRW-1:0];
          fused_d[idx_q[FRW-1:0]] = 1'b1;
          bcnt_d = '0; state_d = S_INRD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN: begin
        // Read entry idx_q; its data arrives in the next cycle.
        pt_raddr = idx_q[PGW-1:0];
        if (idx_q != '0) begin
          if (pt_rdata.present && (!found_q || pt_rdata.count < best_q)) begin
            found_d = 1'b1; best_d = pt_rdata.count;
            victim_d = PGW'(idx_q - 1'b1); vpte_d = pt_rdata;
            frame_d = FRW'(pt_rdata.frame % FRAMES); vdirty_d = pt_rdata.dirty;
          end
        end
        if (idx_q == PGCW'(NPAGES)) begin
          state_d = S_SCANEND;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCANEND: begin
        // Retire the victim; its owner and protection stay.
        ev_d = 1'b1; pt_we = 1'b1; pt_waddr = victim_q;
        pt_wdata = vpte_q; pt_wdata.present = 1'b0; pt_wdata.dirty = 1'b0;
        pt_wdata.count = '0; bcnt_d = '0;
        state_d = vdirty_q ? S_OUTRD : S_INRD;
        wb_d = vdirty_q;
      end
      S_OUTRD: begin
        pm_raddr = {frame_q, OFW'(bcnt_q)}; state_d = S_OUTWR;
      end
      S_OUTWR: begin
        bs_we = 1'b1; bs_waddr = {PGW'(victim_q), OFW'(bcnt_q)}; bs_wdata = pm_rdata;
        if (bcnt_q == BCW'(PAGE_BYTES - 1)) begin
          bcnt_d = '0; state_d = S_INRD;
        end else begin
          bcnt_d = bcnt_q + 1'b1; state_d = S_OUTRD;
        end
      end
      S_INRD: begin
        bs_raddr = {pg, OFW'(bcnt_q)}; state_d = S_INWR;
      end
      S_INWR: begin
        pm_we = 1'b1; pm_waddr = {frame_q, OFW'(bcnt_q)}; pm_wdata = bs_rdata;
        if (bcnt_q == BCW'(PAGE_BYTES - 1)) begin
          state_d = S_FINISH;
        end else begin
          bcnt_d = bcnt_q + 1'b1; state_d = S_INRD;
        end
      end
      S_FINISH: begin
        // Loaded page: present, clean, count zero; owner and prot kept.
        pte_d.present = 1'b1; pte_d.dirty = 1'b0; pte_d.count = '0;
        pte_d.frame = 8'(frame_q); bcnt_d = '0; state_d = S_ACCESS;
      end
      S_ACCESS: begin
        // Read of the byte is issued now; result lands in S_DONE.
        pa_d = 7'(pa_full);
        if (op_q <= OP_EXEC) begin
          if (32'(pte_q.count) < CountMax) pte_d.count = pte_q.count + 1'b1;
          if (!pte_q.prot[op_q[1:0]]) begin
            st_d = 3'(ST_RDENY + op_q);
          end else if (op_q == OP_WRITE) begin
            pm_we = 1'b1; pte_d.dirty = 1'b1;
          end
        end else begin
          st_d = ST_INVOP;
        end
        pt_we = 1'b1; pt_wdata = pte_d; state_d = S_DONE;
        bcnt_d = BCW'(1);
      end
      S_DONE: begin
        done_o = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result ports.
  assign status_o = st_q;
  assign phys_addr_o = pa_q;
  assign read_data_o = (state_q == S_DONE && bcnt_q == BCW'(1) && op_q == OP_READ
                        && st_q == ST_OK) ? pm_rdata : 8'd0;
  assign page_fault_o = pf_q;
  assign evicted_o = ev_q;
  assign wrote_back_o = wb_q;
endmodule

FILE: rtl/tlp_checker.sv
// Port checker for the pager core and its bind statement.
module tlp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [2:0] status_o,
  input logic [7:0] read_data_o,
  input logic       page_fault_o,
  input logic       evicted_o,
  input logic       wrote_back_o
);
  import tlp_pkg::*;
  `include "two_level_pager_lfu_core_defines.svh"
  `TLP_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `TLP_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy)
  `TLP_ASSERT_NEXT(a_done_once, clk_i, rst_ni, done_o, !done_o)
  `TLP_ASSERT_IMP(a_wb_ev, clk_i, rst_ni, done_o && wrote_back_o, evicted_o && page_fault_o)
  `TLP_ASSERT_IMP(a_rd_ok, clk_i, rst_ni, done_o && read_data_o != 8'd0, status_o == ST_OK)
endmodule

bind two_level_pager_lfu_core tlp_checker u_tlp_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o, .read_data_o,
  .page_fault_o, .evicted_o, .wrote_back_o);

FILE: tb/two_level_pager_lfu_core_test.sv
// Self-checking testbench of the two-level demand pager core.
module two_level_pager_lfu_core_test;
  import tlp_pkg::*;

  localparam int NumPages  = 64;
  localparam int PageBytes = 16;
  localparam int NumFrames = 8;
  localparam int NumProcs  = 4;
  localparam int VirtBytes = NumPages * PageBytes;
  localparam int RandItems = 930;

  typedef struct packed {
    status_e    st;
    logic [6:0] pa;
    logic [7:0] rd;
    logic       pf;
    logic       ev;
    logic       wb;
  } pager_res_t;

  typedef struct {
    op_e        op;
    logic [10:0] va;
    logic [2:0] pid;
    logic [7:0] data;
    logic [2:0] prot;
    bit         typed;
    pager_res_t res;
  } pager_req_t;

  logic        clk_i, rst_ni, start, busy, done_o;
  logic [2:0]  op_i, process_id_i, prot_i, status_o;
  logic [10:0] virt_addr_i;
  logic [7:0]  data_i, read_data_o;
  logic [6:0]  phys_addr_o;
  logic        page_fault_o, evicted_o, wrote_back_o;

  two_level_pager_lfu_core dut (.*);

  // Predicted state of the page table, frames and byte stores.
  logic [2:0]  pt_owner [NumPages];
  logic [2:0]  pt_prot [NumPages];
  bit          pt_present [NumPages];
  bit          pt_dirty [NumPages];
  logic [15:0] pt_count [NumPages];
  logic [2:0]  pt_frame [NumPages];
  bit          frame_busy [NumFrames];
  logic [7:0]  frame_mem [NumFrames*PageBytes];
  bit          frame_mem_ok [NumFrames*PageBytes];
  logic [7:0]  backing [VirtBytes];
  bit          backing_ok [VirtBytes];

  pager_res_t pending_results [$];
  int         errors = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("[two_level_pager_lfu_core] ERROR");
    $finish;
  end

  // Computes the answer to one request and updates the predicted state.
  function automatic pager_res_t translate_access(pager_req_t rq);
    pager_res_t r;
    int pg, off, fr, victim, k;
    bit found;
    r = '0;
    r.st = ST_OK;
    if (rq.va >= VirtBytes) begin
      r.st = ST_BOUNDS;
      return r;
    end
    if (rq.op == OP_LOADB) begin
      backing[rq.va] = rq.data;
      backing_ok[rq.va] = 1'b1;
      return r;
    end
    if (rq.pid >= NumProcs) begin
      r.st = ST_PROC;
      return r;
    end
    pg = rq.va / PageBytes;
    off = rq.va % PageBytes;
    if (rq.op == OP_SETATTR) begin
      pt_owner[pg] = rq.pid;
      pt_prot[pg] = rq.prot;
      return r;
    end
    if (pt_owner[pg] != rq.pid) begin
      r.st = ST_OWNER;
      return r;
    end
    if (!pt_present[pg]) begin
      r.pf = 1'b1;
      fr = NumFrames;
      for (k = NumFrames - 1; k >= 0; k--) if (!frame_busy[k]) fr = k;
      if (fr < NumFrames) begin
        frame_busy[fr] = 1'b1;
      end else begin
        // Least-used present page loses its frame; first one wins ties.
        found = 1'b0;
        victim = 0;
        for (k = 0; k < NumPages; k++)
          if (pt_present[k] && (!found || pt_count[k] < pt_count[victim])) begin
            found = 1'b1;
            victim = k;
          end
        fr = pt_frame[victim];
        if (pt_dirty[victim]) begin
          for (k = 0; k < PageBytes; k++) begin
            backing[victim*PageBytes+k] = frame_mem[fr*PageBytes+k];
            backing_ok[victim*PageBytes+k] = frame_mem_ok[fr*PageBytes+k];
          end
          r.wb = 1'b1;
        end
        pt_present[victim] = 1'b0;
        pt_dirty[victim] = 1'b0;
        pt_count[victim] = '0;
        r.ev = 1'b1;
      end
      for (k = 0; k < PageBytes; k++) begin
        frame_mem[fr*PageBytes+k] = backing[pg*PageBytes+k];
        frame_mem_ok[fr*PageBytes+k] = backing_ok[pg*PageBytes+k];
      end
      pt_frame[pg] = 3'(fr);
      pt_present[pg] = 1'b1;
      pt_dirty[pg] = 1'b0;
      pt_count[pg] = '0;
    end
    r.pa = 7'(pt_frame[pg] * PageBytes + off);
    if (rq.op <= OP_EXEC) begin
      if (pt_count[pg] != 16'hFFFF) pt_count[pg]++;
      if (!pt_prot[pg][rq.op]) begin
        r.st = status_e'(ST_RDENY + rq.op);
      end else if (rq.op == OP_READ) begin
        r.rd = frame_mem[r.pa];
      end else if (rq.op == OP_WRITE) begin
        frame_mem[r.pa] = rq.data;
        frame_mem_ok[r.pa] = 1'b1;
        pt_dirty[pg] = 1'b1;
      end
    end else begin
      r.st = ST_INVOP;
    end
    return r;
  endfunction

  // True when a permitted read would return a byte that was never written.
  function automatic bit reads_unwritten(pager_req_t rq);
    int pg;
    if (rq.op != OP_READ || rq.va >= VirtBytes || rq.pid >= NumProcs) return 1'b0;
    pg = rq.va / PageBytes;
    if (pt_owner[pg] != rq.pid || !pt_prot[pg][0]) return 1'b0;
    if (pt_present[pg]) return !frame_mem_ok[pt_frame[pg]*PageBytes + rq.va % PageBytes];
    return !backing_ok[rq.va];
  endfunction

  // Drives one request and waits for its transfer.
  task automatic issue(pager_req_t rq);
    pager_res_t r;
    if (reads_unwritten(rq)) rq.op = OP_LOADB;
    op_i <= rq.op;
    virt_addr_i <= rq.va;
    process_id_i <= rq.pid;
    data_i <= rq.data;
    prot_i <= rq.prot;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    r = translate_access(rq);
    pending_results.push_back(rq.typed ? rq.res : r);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic pager_req_t random_request();
    pager_req_t rq;
    int sel;
    rq.typed = 1'b0;
    rq.res = '0;
    rq.va = 11'($urandom_range(0, VirtBytes - 1));
    rq.data = 8'($urandom);
    rq.prot = 3'($urandom);
    rq.pid = pt_owner[rq.va / PageBytes];
    sel = $urandom_range(0, 99);
    if (sel < 35) rq.op = OP_READ;
    else if (sel < 60) rq.op = OP_WRITE;
    else if (sel < 68) rq.op = OP_EXEC;
    else if (sel < 74) begin
      rq.op = OP_SETATTR;
      rq.pid = 3'($urandom_range(0, NumProcs - 1));
      if ($urandom_range(0, 3) != 0) rq.prot = rq.prot | 3'b011;
    end
    else if (sel < 86) rq.op = OP_LOADB;
    else if (sel < 90) rq.op = op_e'(3'($urandom_range(OP_INV5, OP_INV7)));
    else begin
      // Noise: out of range address, unknown or foreign process.
      rq.op = op_e'(3'($urandom));
      case ($urandom_range(0, 2))
        0: rq.va = 11'($urandom_range(VirtBytes, 2047));
        1: rq.pid = 3'($urandom_range(NumProcs, 7));
        default: rq.pid = 3'($urandom_range(0, 7));
      endcase
    end
    return rq;
  endfunction

  // Directed rows: op, address, process, data, protection, typed answer.
  pager_req_t directed [$];
  function automatic void row(op_e op, int va, int pid, int data, int prot,
                              bit typed = 1'b0, status_e st = ST_OK);
    pager_req_t rq;
    rq.op = op;
    rq.va = 11'(va);
    rq.pid = 3'(pid);
    rq.data = 8'(data);
    rq.prot = 3'(prot);
    rq.typed = typed;
    rq.res = '0;
    rq.res.st = st;
    directed.push_back(rq);
  endfunction

  initial begin
    int i;
    pager_req_t rq;
    foreach (pt_owner[k]) begin
      pt_owner[k] = '0; pt_prot[k] = '0; pt_present[k] = 0;
      pt_dirty[k] = 0; pt_count[k] = '0; pt_frame[k] = '0;
    end
    foreach (frame_busy[k]) frame_busy[k] = 0;
    foreach (frame_mem_ok[k]) begin frame_mem[k] = '0; frame_mem_ok[k] = 0; end
    foreach (backing_ok[k]) begin backing[k] = '0; backing_ok[k] = 0; end
    rst_ni = 1'b0;
    start = 1'b0;
    op_i = '0; virt_addr_i = '0; process_id_i = '0; data_i = '0; prot_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    row(OP_LOADB, 0, 0, 8'hA5, 0, 1'b1, ST_OK);
    row(OP_LOADB, 2047, 7, 8'hFF, 7, 1'b1, ST_BOUNDS);
    row(OP_READ, 1024, 0, 0, 0, 1'b1, ST_BOUNDS);
    row(OP_READ, 0, 7, 0, 0, 1'b1, ST_PROC);
    row(OP_SETATTR, 0, 4, 0, 7, 1'b1, ST_PROC);
    row(OP_READ, 16, 1, 0, 0, 1'b1, ST_OWNER);
    row(OP_SETATTR, 0, 0, 0, 7, 1'b1, ST_OK);
    row(OP_READ, 0, 0, 0, 0);
    row(OP_WRITE, 1, 0, 8'hFF, 0);
    row(OP_READ, 1, 0, 0, 0);
    row(OP_EXEC, 2, 0, 0, 0);
    row(OP_INV5, 0, 0, 0, 0);
    row(OP_INV6, 3, 0, 0, 0);
    row(OP_INV7, 15, 0, 0, 0);
    row(OP_SETATTR, 1023, 3, 0, 0, 1'b1, ST_OK);
    row(OP_READ, 1023, 3, 0, 0);
    row(OP_WRITE, 1023, 3, 8'h00, 0);
    row(OP_EXEC, 1023, 3, 0, 0);
    row(OP_LOADB, 1023, 3, 8'h00, 0, 1'b1, ST_OK);
    row(OP_SETATTR, 1023, 3, 0, 7, 1'b1, ST_OK);
    row(OP_READ, 1023, 3, 0, 0);
    row(OP_LOADB, 1023, 3, 8'h3C, 0, 1'b1, ST_OK);
    row(OP_READ, 1023, 3, 0, 0);
    foreach (directed[k]) issue(directed[k]);

    // Random traffic with bursts of idle time, none in the last stretch.
    for (i = 0; i < RandItems; i++) begin
      if (i == RandItems / 2) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if (i < RandItems - 100 && $urandom_range(0, 4) == 0)
        idle_cycles($urandom_range(1, 10));
      rq = random_request();
      issue(rq);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("[two_level_pager_lfu_core] OK");
    end else begin
      $display("[two_level_pager_lfu_core] ERROR");
    end
    $finish;
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    pager_res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, status_o);
          errors++;
        end
        if (phys_addr_o !== want.pa) begin
          $display("%0t: phys_addr expected %0d got %0d", $time, want.pa, phys_addr_o);
          errors++;
        end
        if (read_data_o !== want.rd) begin
          $display("%0t: read_data expected %h got %h", $time, want.rd, read_data_o);
          errors++;
        end
        if (page_fault_o !== want.pf) begin
          $display("%0t: page_fault expected %b got %b", $time, want.pf, page_fault_o);
          errors++;
        end
        if (evicted_o !== want.ev) begin
          $display("%0t: evicted expected %b got %b", $time, want.ev, evicted_o);
          errors++;
        end
        if (wrote_back_o !== want.wb) begin
          $display("%0t: wrote_back expected %b got %b", $time, want.wb, wrote_back_o);
          errors++;
        end
      end
    end
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/tlp_pkg.sv
rtl/tlp_page_mem.sv
rtl/tlp_byte_mem.sv
rtl/two_level_pager_lfu_core.sv
rtl/tlp_checker.sv
tb/two_level_pager_lfu_core_test.sv
